[design/tun_pkg.sv]
package tun_pkg;

    // Default sizes of the coordinate and result fraction fields
    localparam int COORD_BITS_DEF       = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 15;

    // Result component format (signed Q1.15 container)
    localparam int OUT_W = 16;

    // Saturation limits of a component, as magnitudes
    localparam logic [OUT_W:0] SAT_POS_MAG = (OUT_W + 1)'(32767);
    localparam logic [OUT_W:0] SAT_NEG_MAG = (OUT_W + 1)'(32768);

    // Control word that travels down the chain beside the data
    typedef struct packed {
        logic       vld;
        logic       degen;
        logic [2:0] neg;
    } tun_ctl_t;

endpackage

[design/tun_tri_if.sv]
interface tun_tri_if #(
    parameter int COORD_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] vertex_a_x;
    logic [COORD_BITS-1:0] vertex_a_y;
    logic [COORD_BITS-1:0] vertex_a_z;
    logic [COORD_BITS-1:0] vertex_b_x;
    logic [COORD_BITS-1:0] vertex_b_y;
    logic [COORD_BITS-1:0] vertex_b_z;
    logic [COORD_BITS-1:0] vertex_c_x;
    logic [COORD_BITS-1:0] vertex_c_y;
    logic [COORD_BITS-1:0] vertex_c_z;

    modport source (
        output valid, vertex_a_x, vertex_a_y, vertex_a_z,
               vertex_b_x, vertex_b_y, vertex_b_z,
               vertex_c_x, vertex_c_y, vertex_c_z,
        input  ready
    );

    modport sink (
        input  valid, vertex_a_x, vertex_a_y, vertex_a_z,
               vertex_b_x, vertex_b_y, vertex_b_z,
               vertex_c_x, vertex_c_y, vertex_c_z,
        output ready
    );
endinterface

[design/tun_norm_if.sv]
interface tun_norm_if;
    logic        valid;
    logic        ready;
    logic [15:0] normal_x;
    logic [15:0] normal_y;
    logic [15:0] normal_z;
    logic        degenerate;

    modport source (
        output valid, normal_x, normal_y, normal_z, degenerate,
        input  ready
    );

    modport sink (
        input  valid, normal_x, normal_y, normal_z, degenerate,
        output ready
    );
endinterface

[design/tun_cross.sv]
module tun_cross #(
    parameter int CB = 16,
    parameter int MW = 2 * CB + 2,
    parameter int SW = 2 * MW + 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [CB-1:0]      coord [9],
    output tun_pkg::tun_ctl_t  ctl_o,
    output logic [MW-1:0]      mag_o [3],
    output logic [SW-1:0]      sum_o
);
    import tun_pkg::*;

    localparam int EW  = CB + 1;
    localparam int PW  = 2 * EW;
    localparam int NW  = PW + 1;
    localparam int LB  = MW / 2;
    localparam int HB  = MW - LB;
    localparam int SQW = 2 * MW;

    tun_ctl_t ctl_reg [7];
    tun_ctl_t ctl_next [7];

    logic signed [EW-1:0] e_reg  [6];
    logic signed [EW-1:0] e_next [6];
    logic signed [PW-1:0] p_reg  [6];
    logic signed [PW-1:0] p_next [6];
    logic signed [NW-1:0] n_reg  [3];
    logic signed [NW-1:0] n_next [3];

    logic [MW-1:0]     mag4_reg [3];
    logic [MW-1:0]     mag4_next [3];
    logic [MW-1:0]     mag5_reg [3];
    logic [MW-1:0]     mag6_reg [3];
    logic [MW-1:0]     mag7_reg [3];
    logic [2*HB-1:0]   hh_reg  [3];
    logic [2*HB-1:0]   hh_next [3];
    logic [MW-1:0]     hl_reg  [3];
    logic [MW-1:0]     hl_next [3];
    logic [2*LB-1:0]   ll_reg  [3];
    logic [2*LB-1:0]   ll_next [3];
    logic [SQW-1:0]    sq_reg  [3];
    logic [SQW-1:0]    sq_next [3];
    logic [SW-1:0]     s_reg;
    logic [SW-1:0]     s_next;
    logic [HB-1:0]     hi_half [3];
    logic [LB-1:0]     lo_half [3];

    // Edge vectors b-a and c-a
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            e_next[k] = $signed({coord[k + 3][CB-1], coord[k + 3]})
                      - $signed({coord[k % 3][CB-1], coord[k % 3]});
        end
    end

    // Cross product terms
    always_comb
    begin
        p_next[0] = e_reg[1] * e_reg[5];
        p_next[1] = e_reg[2] * e_reg[4];
        p_next[2] = e_reg[2] * e_reg[3];
        p_next[3] = e_reg[0] * e_reg[5];
        p_next[4] = e_reg[0] * e_reg[4];
        p_next[5] = e_reg[1] * e_reg[3];
        for (int c = 0; c < 3; c++)
        begin
            n_next[c] = p_reg[2*c] - p_reg[2*c + 1];
        end
    end

    // Magnitude of each component; its sign and zero test go into the control word
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            mag4_next[c] = n_reg[c][NW-1] ? MW'(-n_reg[c]) : MW'(n_reg[c]);
        end
    end

    // Squares in halves, then assembled, then summed
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            hi_half[c] = mag4_reg[c][MW-1:LB];
            lo_half[c] = mag4_reg[c][LB-1:0];
            hh_next[c] = hi_half[c] * hi_half[c];
            hl_next[c] = MW'(hi_half[c] * lo_half[c]);
            ll_next[c] = lo_half[c] * lo_half[c];
            sq_next[c] = SQW'({hh_reg[c], (2*LB)'(0)})
                       + SQW'({hl_reg[c], (LB+1)'(0)})
                       + SQW'(ll_reg[c]);
        end
        s_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
    end

    // Control alongside the data
    always_comb
    begin
        ctl_next[0]     = '0;
        ctl_next[0].vld = in_vld;
        for (int k = 1; k < 7; k++)
        begin
            ctl_next[k] = ctl_reg[k - 1];
        end
        ctl_next[3].degen = (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);
        for (int c = 0; c < 3; c++)
        begin
            ctl_next[3].neg[c] = n_reg[c][NW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 7; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < 7; k++)
            begin
                ctl_reg[k] <= ctl_next[k];
            end
        end
    end

    // Data path, no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg <= e_next;
            p_reg <= p_next;
            n_reg <= n_next;
            mag4_reg <= mag4_next;
            mag5_reg <= mag4_reg;
            mag6_reg <= mag5_reg;
            mag7_reg <= mag6_reg;
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            ll_reg <= ll_next;
            sq_reg <= sq_next;
            s_reg  <= s_next;
        end
    end

    assign ctl_o = ctl_reg[6];
    assign mag_o = mag7_reg;
    assign sum_o = s_reg;

endmodule

[design/tun_sqrt_cell.sv]
module tun_sqrt_cell #(
    parameter int RW = 35,
    parameter int SW = 70,
    parameter int MW = 34
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  tun_pkg::tun_ctl_t  ctl_i,
    input  logic [SW-1:0]      rad_i,
    input  logic [RW+1:0]      rem_i,
    input  logic [RW-1:0]      root_i,
    input  logic [MW-1:0]      mag_i [3],
    output tun_pkg::tun_ctl_t  ctl_o,
    output logic [SW-1:0]      rad_o,
    output logic [RW+1:0]      rem_o,
    output logic [RW-1:0]      root_o,
    output logic [MW-1:0]      mag_o [3]
);
    import tun_pkg::*;

    tun_ctl_t      ctl_reg;
    logic [SW-1:0] rad_reg;
    logic [RW+1:0] rem_reg;
    logic [RW+1:0] rem_next;
    logic [RW-1:0] root_reg;
    logic [RW-1:0] root_next;
    logic [MW-1:0] mag_reg [3];
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    logic          ge;

    // One root digit: bring down two radicand bits and try 4q+1
    always_comb
    begin
        cur       = {rem_i, rad_i[SW-1:SW-2]};
        trial     = {2'b00, root_i, 2'b01};
        ge        = (cur >= trial);
        rem_next  = ge ? (RW+2)'(cur - trial) : (RW+2)'(cur);
        root_next = {root_i[RW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_i << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            mag_reg  <= mag_i;
        end
    end

    assign ctl_o  = ctl_reg;
    assign rad_o  = rad_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;
    assign mag_o  = mag_reg;

endmodule

[design/tun_div_cell.sv]
module tun_div_cell #(
    parameter int RW    = 35,
    parameter int QW    = 16,
    parameter bit FIRST = 1'b0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  tun_pkg::tun_ctl_t  ctl_i,
    input  logic [RW-1:0]      len_i,
    input  logic [RW-1:0]      rem_i [3],
    input  logic [QW-1:0]      q_i   [3],
    output tun_pkg::tun_ctl_t  ctl_o,
    output logic [RW-1:0]      len_o,
    output logic [RW-1:0]      rem_o [3],
    output logic [QW-1:0]      q_o   [3]
);
    import tun_pkg::*;

    tun_ctl_t      ctl_reg;
    logic [RW-1:0] len_reg;
    logic [RW-1:0] rem_reg  [3];
    logic [RW-1:0] rem_next [3];
    logic [QW-1:0] q_reg    [3];
    logic [QW-1:0] q_next   [3];
    logic [RW:0]   cur      [3];
    logic          ge       [3];

    // One quotient bit for each component against the shared length
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            cur[c]      = FIRST ? {1'b0, rem_i[c]} : {rem_i[c], 1'b0};
            ge[c]       = (cur[c] >= {1'b0, len_i});
            rem_next[c] = ge[c] ? RW'(cur[c] - {1'b0, len_i}) : RW'(cur[c]);
            q_next[c]   = {q_i[c][QW-2:0], ge[c]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg <= len_i;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign ctl_o = ctl_reg;
    assign len_o = len_reg;
    assign rem_o = rem_reg;
    assign q_o   = q_reg;

endmodule

[design/triangle_unit_normal.sv]
// Unit face normal of a triangle.
// tri_in carries three vertices a, b, c of signed Q8.8 coordinates; norm_out
// returns the unit normal of (b-a) x (c-a) in signed Q1.15 and a degenerate
// flag, set with all components zero when the cross product is zero.
// Both channels transfer on a clock edge with valid and ready high.
// Throughput: one triangle per cycle while the skid register is empty, with
// no dependence between items. From input transfer to norm_out.valid an
// item passes seven stages forming the edges, the cross product and the
// squared length, then the cell chains, one cell per root bit of the square
// root and one per quotient bit of the division, then the output register.
// Reset clears every valid bit; nothing is in flight afterwards.
// When the receiver stalls, a result waits in the output register and one
// more in a skid register; tri_in.ready falls only once the skid register is
// full, and the whole chain then holds. ready comes from a flop.
module triangle_unit_normal #(
    parameter int COORD_BITS       = tun_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tun_tri_if.sink     tri_in,
    tun_norm_if.source  norm_out
);
    import tun_pkg::*;

    localparam int MW = 2 * COORD_BITS + 2;
    localparam int SW = 2 * MW + 2;
    localparam int RW = MW + 1;
    localparam int QW = NORMAL_FRAC_BITS + 1;
    localparam int QX = (QW > OUT_W + 1) ? QW : OUT_W + 1;

    logic en;
    logic [COORD_BITS-1:0] coord [9];

    tun_ctl_t      sq_ctl  [RW+1];
    logic [SW-1:0] sq_rad  [RW+1];
    logic [RW+1:0] sq_rem  [RW+1];
    logic [RW-1:0] sq_root [RW+1];
    logic [MW-1:0] sq_mag  [RW+1][3];

    tun_ctl_t      dv_ctl [QW+1];
    logic [RW-1:0] dv_len [QW+1];
    logic [RW-1:0] dv_rem [QW+1][3];
    logic [QW-1:0] dv_q   [QW+1][3];

    logic [QX-1:0]    qx    [3];
    logic [OUT_W:0]   qmag  [3];
    logic [OUT_W-1:0] comp  [3];
    tun_ctl_t         tail;
    logic             tail_vld;

    logic             out_vld_reg;
    logic [OUT_W-1:0] out_reg  [3];
    logic             out_deg_reg;
    logic             skid_vld_reg;
    logic [OUT_W-1:0] skid_reg [3];
    logic             skid_deg_reg;

    // Whole chain moves unless a result sits in the skid register
    assign en           = !skid_vld_reg;
    assign tri_in.ready = en;

    assign coord[0] = tri_in.vertex_a_x;
    assign coord[1] = tri_in.vertex_a_y;
    assign coord[2] = tri_in.vertex_a_z;
    assign coord[3] = tri_in.vertex_b_x;
    assign coord[4] = tri_in.vertex_b_y;
    assign coord[5] = tri_in.vertex_b_z;
    assign coord[6] = tri_in.vertex_c_x;
    assign coord[7] = tri_in.vertex_c_y;
    assign coord[8] = tri_in.vertex_c_z;

    // Edges, cross product and squared length
    tun_cross #(
        .CB (COORD_BITS),
        .MW (MW),
        .SW (SW)
    ) u_cross (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_vld (tri_in.valid),
        .coord  (coord),
        .ctl_o  (sq_ctl[0]),
        .mag_o  (sq_mag[0]),
        .sum_o  (sq_rad[0])
    );

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    // Square root, one root bit per cell
    for (genvar i = 0; i < RW; i++)
    begin : g_sqrt
        tun_sqrt_cell #(
            .RW (RW),
            .SW (SW),
            .MW (MW)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .ctl_i  (sq_ctl[i]),
            .rad_i  (sq_rad[i]),
            .rem_i  (sq_rem[i]),
            .root_i (sq_root[i]),
            .mag_i  (sq_mag[i]),
            .ctl_o  (sq_ctl[i+1]),
            .rad_o  (sq_rad[i+1]),
            .rem_o  (sq_rem[i+1]),
            .root_o (sq_root[i+1]),
            .mag_o  (sq_mag[i+1])
        );
    end

    assign dv_ctl[0] = sq_ctl[RW];
    assign dv_len[0] = sq_root[RW];
    for (genvar c = 0; c < 3; c++)
    begin : g_dv_in
        assign dv_rem[0][c] = RW'(sq_mag[RW][c]);
        assign dv_q[0][c]   = '0;
    end

    // Division by the length, one quotient bit per cell
    for (genvar i = 0; i < QW; i++)
    begin : g_div
        tun_div_cell #(
            .RW    (RW),
            .QW    (QW),
            .FIRST ((i == 0) ? 1'b1 : 1'b0)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .ctl_i (dv_ctl[i]),
            .len_i (dv_len[i]),
            .rem_i (dv_rem[i]),
            .q_i   (dv_q[i]),
            .ctl_o (dv_ctl[i+1]),
            .len_o (dv_len[i+1]),
            .rem_o (dv_rem[i+1]),
            .q_o   (dv_q[i+1])
        );
    end

    // Sign, saturation and degenerate zeroing into the 16-bit result
    always_comb
    begin
        tail     = dv_ctl[QW];
        tail_vld = tail.vld && en;
        for (int c = 0; c < 3; c++)
        begin
            qx[c] = QX'(dv_q[QW][c]);
            if (tail.neg[c])
            begin
                qmag[c] = (qx[c] > QX'(SAT_NEG_MAG)) ? SAT_NEG_MAG : (OUT_W+1)'(qx[c]);
                comp[c] = OUT_W'(-qmag[c]);
            end
            else
            begin
                qmag[c] = (qx[c] > QX'(SAT_POS_MAG)) ? SAT_POS_MAG : (OUT_W+1)'(qx[c]);
                comp[c] = OUT_W'(qmag[c]);
            end
            if (tail.degen)
            begin
                comp[c] = '0;
            end
        end
    end

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_vld_reg && !norm_out.ready)
        begin
            if (tail_vld)
            begin
                skid_vld_reg <= 1'b1;
            end
        end
        else if (skid_vld_reg)
        begin
            out_vld_reg  <= 1'b1;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= tail_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_vld_reg && !norm_out.ready)
        begin
            if (tail_vld)
            begin
                skid_reg     <= comp;
                skid_deg_reg <= tail.degen;
            end
        end
        else if (skid_vld_reg)
        begin
            out_reg     <= skid_reg;
            out_deg_reg <= skid_deg_reg;
        end
        else if (tail_vld)
        begin
            out_reg     <= comp;
            out_deg_reg <= tail.degen;
        end
    end

    assign norm_out.valid      = out_vld_reg;
    assign norm_out.normal_x   = out_reg[0];
    assign norm_out.normal_y   = out_reg[1];
    assign norm_out.normal_z   = out_reg[2];
    assign norm_out.degenerate = out_deg_reg;

endmodule

[bench/triangle_unit_normal_tb_if.sv]
// Interfaces come from the design; this file holds the bench-side transfer types.
package tun_tb_types_pkg;

    typedef struct {
        logic [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    } tri_item_t;

    typedef struct {
        logic [15:0] nx, ny, nz;
        logic        degen;
    } normal_item_t;

endpackage

[bench/triangle_unit_normal_tb.sv]
module triangle_unit_normal_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tun_tb_types_pkg::*;

    // Expected unit normals and the predictor that fills them
    class normal_scoreboard;
        normal_item_t pending[$];
        int           errors;

        function automatic logic [15:0] unit_comp(logic signed [33:0] n,
                                                  logic [33:0] len);
            logic [33:0] mag;
            logic [49:0] q;
            mag = n < 0 ? -n : n;
            q = ({16'd0, mag} << 15) / len;
            if (n < 0)
            begin
                if (q > 50'd32768)
                    q = 50'd32768;
                return 16'(-q);
            end
            if (q > 50'd32767)
                q = 50'd32767;
            return q[15:0];
        endfunction

        function void note_triangle(tri_item_t t);
            logic signed [33:0] e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
            logic [69:0]        sq;
            logic [35:0]        len, cand;
            normal_item_t       r;
            e1x = $signed(t.bx) - $signed(t.ax);
            e1y = $signed(t.by) - $signed(t.ay);
            e1z = $signed(t.bz) - $signed(t.az);
            e2x = $signed(t.cx) - $signed(t.ax);
            e2y = $signed(t.cy) - $signed(t.ay);
            e2z = $signed(t.cz) - $signed(t.az);
            nx = e1y * e2z - e1z * e2y;
            ny = e1z * e2x - e1x * e2z;
            nz = e1x * e2y - e1y * e2x;
            sq = 70'(nx * nx) + 70'(ny * ny) + 70'(nz * nz);
            r.degen = (sq == 0);
            r.nx = 0; r.ny = 0; r.nz = 0;
            if (!r.degen)
            begin
                // bitwise floor square root
                len = 0;
                for (int b = 35; b >= 0; b--)
                begin
                    cand = len | (36'd1 << b);
                    if (72'(cand) * 72'(cand) <= 72'(sq))
                        len = cand;
                end
                r.nx = unit_comp(nx, len[33:0]);
                r.ny = unit_comp(ny, len[33:0]);
                r.nz = unit_comp(nz, len[33:0]);
            end
            pending.push_back(r);
        endfunction

        function void check_normal(normal_item_t got);
            normal_item_t exp_r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result nx=%h ny=%h nz=%h degen=%b", $time,
                         got.nx, got.ny, got.nz, got.degen);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.nx !== exp_r.nx || got.ny !== exp_r.ny || got.nz !== exp_r.nz
                || got.degen !== exp_r.degen)
            begin
                $display("%0t: mismatch expected %h %h %h %b actual %h %h %h %b", $time,
                         exp_r.nx, exp_r.ny, exp_r.nz, exp_r.degen,
                         got.nx, got.ny, got.nz, got.degen);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY = 59;

    logic clk = 0;
    logic rst_n = 0;

    tun_tri_if #(.COORD_BITS(16)) tri_in ();
    tun_norm_if norm_out ();

    triangle_unit_normal dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .tri_in   (tri_in.sink),
        .norm_out (norm_out.source)
    );

    always #5 clk = ~clk;

    normal_scoreboard sb = new();
    int  send_idle_pct = 15;
    int  recv_idle_pct = 46;
    bit  hold_off = 0;

    initial
    begin
        tri_in.valid = 0;
        {tri_in.vertex_a_x, tri_in.vertex_a_y, tri_in.vertex_a_z} = '0;
        {tri_in.vertex_b_x, tri_in.vertex_b_y, tri_in.vertex_b_z} = '0;
        {tri_in.vertex_c_x, tri_in.vertex_c_y, tri_in.vertex_c_z} = '0;
        norm_out.ready = 0;
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (norm_out.valid && norm_out.ready)
                sb.check_normal('{norm_out.normal_x, norm_out.normal_y,
                                  norm_out.normal_z, norm_out.degenerate});
            norm_out.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one triangle and wait for its transfer
    task automatic send_triangle(tri_item_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tri_in.valid <= 0;
            @(posedge clk);
        end
        tri_in.valid      <= 1;
        tri_in.vertex_a_x <= t.ax; tri_in.vertex_a_y <= t.ay; tri_in.vertex_a_z <= t.az;
        tri_in.vertex_b_x <= t.bx; tri_in.vertex_b_y <= t.by; tri_in.vertex_b_z <= t.bz;
        tri_in.vertex_c_x <= t.cx; tri_in.vertex_c_y <= t.cy; tri_in.vertex_c_z <= t.cz;
        do
            @(posedge clk);
        while (!tri_in.ready);
        sb.note_triangle(t);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic tri_item_t random_triangle();
        tri_item_t t;
        t = '{pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
              pick_coord(), pick_coord(), pick_coord(), pick_coord()};
        // collinear or coincident vertices now and then
        case ($urandom_range(9))
            0: begin t.bx = t.ax; t.by = t.ay; t.bz = t.az; end
            1: begin t.cx = t.bx; t.cy = t.by; t.cz = t.bz; end
            default: ;
        endcase
        return t;
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: axis triangles, degenerate cases, extremes
        send_triangle('{0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100, 0});
        send_triangle('{0, 0, 0, 0, 16'h0100, 0, 16'h0100, 0, 0});
        send_triangle('{0, 0, 0, 0, 0, 16'h0100, 16'h0100, 0, 0});
        send_triangle('{0, 0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100});
        send_triangle('{0, 0, 0, 0, 0, 16'h0100, 0, 16'h0100, 0});
        send_triangle('{5, 6, 7, 5, 6, 7, 5, 6, 7});
        send_triangle('{0, 0, 0, 1, 1, 1, 2, 2, 2});
        send_triangle('{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                        16'h8000, 16'h7fff, 16'h8000});
        send_triangle('{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
                        16'h7fff, 16'h7fff, 16'h8000});
        send_triangle('{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                        16'h8000, 16'h8000, 16'h7fff});
        send_triangle('{16'hffff, 16'hffff, 16'hffff, 0, 0, 0, 16'h5555, 16'haaaa,
                        16'h1234});
        send_triangle('{0, 0, 0, 1, 0, 0, 0, 1, 0});
        send_triangle('{0, 0, 0, 3, 1, 0, 1, 2, 0});

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (200) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 80; i++)
                send_triangle(random_triangle());
        join

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = phase == 0 ? 15 : phase == 1 ? 46 : 0;
            recv_idle_pct = phase == 0 ? 46 : phase == 1 ? 15 : 0;
            for (int i = 0; i < 120; i++)
                send_triangle(random_triangle());
        end
        tri_in.valid <= 0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("triangle_unit_normal_tb passed");
        else
            $display("triangle_unit_normal_tb failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2ms;
        $display("triangle_unit_normal_tb failed");
        $finish;
    end
endmodule

[triangle_unit_normal.f]
design/tun_pkg.sv
design/tun_tri_if.sv
design/tun_norm_if.sv
design/tun_cross.sv
design/tun_sqrt_cell.sv
design/tun_div_cell.sv
design/triangle_unit_normal.sv
bench/triangle_unit_normal_tb_if.sv
bench/triangle_unit_normal_tb.sv
